// ----- design/acpc_pkg.sv -----
// ----------------------------------------------------------------------------
// acpc_pkg: shared types and tables for the frame payload cipher
// Holds the AES S-box, round constants, GF(2^8) helpers and the side-band
// record that travels through the round pipeline next to the cipher state.
// ----------------------------------------------------------------------------
package acpc_pkg;

   localparam int unsigned BLOCK_BYTES = 16;
   localparam int unsigned BLOCK_BITS  = 128;
   localparam int unsigned ROUNDS      = 10;
   localparam int unsigned COUNT_W     = 5;

   localparam logic [7:0] CTR_FLAG_BYTE = 8'h01;
   localparam logic [7:0] INDEX_RESET   = 8'h01;
   localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(BLOCK_BYTES);

   // Register indexes of the configuration port (address bits 4:3).
   localparam logic [1:0] REG_KEY_LOW  = 2'd0;
   localparam logic [1:0] REG_KEY_HIGH = 2'd1;
   localparam logic [1:0] REG_DEV_ADDR = 2'd2;

   // Payload bytes and saturated byte count carried beside the cipher state.
   typedef struct packed {
      logic [BLOCK_BITS-1:0] data;
      logic [COUNT_W-1:0]    count;
   } side_type;

   localparam logic [7:0] RCON_TABLE [0:ROUNDS-1] = '{
      8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
   };

   localparam logic [7:0] SBOX_TABLE [0:255] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic logic [7:0] sbox(input logic [7:0] x);
      return SBOX_TABLE[x];
   endfunction

   // Multiply by two in GF(2^8).
   function automatic logic [7:0] xtime(input logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

endpackage

// ----- design/acpc_lane.sv -----
// ----------------------------------------------------------------------------
// acpc_lane: one column lane of an AES round
// Substitutes the four bytes of one column, mixes them unless this is the
// final round, and adds the column of the round key.
// ----------------------------------------------------------------------------
module acpc_lane
   import acpc_pkg::*;
(
   input  logic [31:0] col_in,
   input  logic [31:0] key_col,
   input  logic        last,
   output logic [31:0] col_out
);

   logic [7:0] a0, a1, a2, a3, all;
   logic [31:0] mixed;

   always_comb begin
      a0  = sbox(col_in[7:0]);
      a1  = sbox(col_in[15:8]);
      a2  = sbox(col_in[23:16]);
      a3  = sbox(col_in[31:24]);
      all = a0 ^ a1 ^ a2 ^ a3;
      if (last) begin
         mixed = {a3, a2, a1, a0};
      end else begin
         mixed = {a3 ^ all ^ xtime(a3 ^ a0),
                  a2 ^ all ^ xtime(a2 ^ a3),
                  a1 ^ all ^ xtime(a1 ^ a2),
                  a0 ^ all ^ xtime(a0 ^ a1)};
      end
      col_out = mixed ^ key_col;
   end

endmodule

// ----- design/acpc_round.sv -----
// ----------------------------------------------------------------------------
// acpc_round: one registered AES round stage
// Four column lanes work side by side on the shifted state; the round key is
// expanded in the same stage and registered with the state.
// ----------------------------------------------------------------------------
module acpc_round
   import acpc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  valid_prev,
   input  logic [BLOCK_BITS-1:0] state_prev,
   input  logic [BLOCK_BITS-1:0] key_prev,
   input  side_type              side_prev,
   input  logic [7:0]            rcon,
   input  logic                  last,
   output logic                  valid_ff,
   output logic [BLOCK_BITS-1:0] state_ff,
   output logic [BLOCK_BITS-1:0] key_ff,
   output side_type              side_ff
);

   logic [BLOCK_BITS-1:0] shifted;
   logic [BLOCK_BITS-1:0] state_in;
   logic [BLOCK_BITS-1:0] key_in;
   logic [31:0]           rot_word;
   logic                  valid_in;

   // ShiftRows: row r of column c comes from column (c + r) mod 4.
   for (genvar c = 0; c < 4; c++) begin : g_col
      for (genvar r = 0; r < 4; r++) begin : g_row
         assign shifted[8*(r+4*c) +: 8] = state_prev[8*(r+4*((c+r)%4)) +: 8];
      end
      acpc_lane u_lane (
         .col_in  (shifted[32*c +: 32]),
         .key_col (key_in[32*c +: 32]),
         .last    (last),
         .col_out (state_in[32*c +: 32])
      );
   end

   always_comb begin
      rot_word = {sbox(key_prev[103:96]), sbox(key_prev[127:120]),
                  sbox(key_prev[119:112]), sbox(key_prev[111:104]) ^ rcon};
      key_in[31:0]   = key_prev[31:0]   ^ rot_word;
      key_in[63:32]  = key_prev[63:32]  ^ key_in[31:0];
      key_in[95:64]  = key_prev[95:64]  ^ key_in[63:32];
      key_in[127:96] = key_prev[127:96] ^ key_in[95:64];
      valid_in       = advance ? valid_prev : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         state_ff <= state_in;
         key_ff   <= key_in;
         side_ff  <= side_prev;
      end
   end

endmodule

// ----- design/aes128_ctr_frame_payload_cipher.sv -----
// ----------------------------------------------------------------------------
// aes128_ctr_frame_payload_cipher: AES-128 counter-mode frame payload cipher
// Builds the counter block for each payload word, runs it through a ten-round
// pipeline with on-the-fly key expansion and merges the keystream into the
// payload bytes.
// ----------------------------------------------------------------------------
// From acceptance to the result word a word passes one key-add stage, ten
// round stages (four column lanes each) and one merge stage. The pipeline
// takes one word per cycle unless the result side stalls; stalls back up
// stage by stage, so it keeps taking words until all twelve stages are full.
// Reset (synchronous, active high) empties the pipeline, clears the key and
// device address registers and sets the block index to one.
// ----------------------------------------------------------------------------
module aes128_ctr_frame_payload_cipher
   import acpc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Input words
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_first_block,
   input  logic [7:0]            req_direction,
   input  logic [31:0]           req_frame_counter,
   input  logic [63:0]           req_data_low,
   input  logic [63:0]           req_data_high,
   input  logic [COUNT_W-1:0]    req_byte_count,
   // Result words
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [63:0]           rsp_result_low,
   output logic [63:0]           rsp_result_high,
   output logic [COUNT_W-1:0]    rsp_result_count,
   // Configuration port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [4:0]            csr_paddr,
   input  logic [63:0]           csr_pwdata,
   output logic [63:0]           csr_prdata,
   output logic                  csr_pready
);

   // Configuration registers. Each register sits at an 8-byte slot, so
   // address bits 4:3 pick it.
   logic [63:0] key_low_ff, key_low_in;
   logic [63:0] key_high_ff, key_high_in;
   logic [31:0] dev_addr_ff, dev_addr_in;
   logic        csr_write;

   // Block index for words that continue a frame.
   logic [7:0] block_index_ff, block_index_in;
   logic [7:0] index_used;

   // Stage 0: counter block with the first round key added.
   logic                  valid0_ff, valid0_in;
   logic [BLOCK_BITS-1:0] state0_ff, key0_ff;
   side_type              side0_ff;
   logic [BLOCK_BITS-1:0] ctr_block, key_full;
   side_type              side_req;
   logic [COUNT_W-1:0]    count_sat;

   // Round stages 1 to 10, index r holds the output of round r+1.
   logic                  rnd_valid [0:ROUNDS-1];
   logic [BLOCK_BITS-1:0] rnd_state [0:ROUNDS-1];
   logic [BLOCK_BITS-1:0] rnd_key   [0:ROUNDS-1];
   side_type              rnd_side  [0:ROUNDS-1];
   logic                  rnd_adv   [0:ROUNDS-1];

   // Merge stage: the result register.
   logic                  out_valid_ff, out_valid_in;
   logic [BLOCK_BITS-1:0] out_data_ff, out_data_in;
   logic [COUNT_W-1:0]    out_count_ff;
   logic                  out_adv;
   logic                  adv0;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      key_low_in  = key_low_ff;
      key_high_in = key_high_ff;
      dev_addr_in = dev_addr_ff;
      if (csr_write) begin
         unique case (csr_paddr[4:3])
            REG_KEY_LOW:  key_low_in  = csr_pwdata;
            REG_KEY_HIGH: key_high_in = csr_pwdata;
            REG_DEV_ADDR: dev_addr_in = csr_pwdata[31:0];
            default:      ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[4:3])
         REG_KEY_LOW:  csr_prdata = key_low_ff;
         REG_KEY_HIGH: csr_prdata = key_high_ff;
         REG_DEV_ADDR: csr_prdata = {32'd0, dev_addr_ff};
         default:      csr_prdata = 64'd0;
      endcase
   end

   // A stage moves forward when it is empty or the next stage moves as well;
   // the chain runs from the result register back to the input.
   always_comb begin
      out_adv = !out_valid_ff || rsp_ready;
   end

   for (genvar r = ROUNDS - 1; r >= 0; r--) begin : g_adv
      if (r == ROUNDS - 1) begin : g_last
         assign rnd_adv[r] = !rnd_valid[r] || out_adv;
      end else begin : g_mid
         assign rnd_adv[r] = !rnd_valid[r] || rnd_adv[r+1];
      end
   end

   assign adv0      = !valid0_ff || rnd_adv[0];
   assign req_ready = adv0;

   // Counter block: flag byte, four zero bytes, direction, device address and
   // frame counter little-endian, a zero pad byte, then the block index.
   always_comb begin
      index_used     = req_first_block ? INDEX_RESET : block_index_ff;
      block_index_in = block_index_ff;
      if (req_valid && req_ready) begin
         block_index_in = index_used + 8'd1;
      end
      ctr_block = {index_used, 8'h00, req_frame_counter, dev_addr_ff,
                   req_direction, 32'h0000_0000, CTR_FLAG_BYTE};
      key_full  = {key_high_ff, key_low_ff};
      // Byte counts above a full block are treated as a full block.
      count_sat = (req_byte_count > FULL_COUNT) ? FULL_COUNT : req_byte_count;
      side_req.data  = {req_data_high, req_data_low};
      side_req.count = count_sat;
      valid0_in = adv0 ? req_valid : valid0_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff     <= 64'd0;
         key_high_ff    <= 64'd0;
         dev_addr_ff    <= 32'd0;
         block_index_ff <= INDEX_RESET;
         valid0_ff      <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         key_low_ff     <= key_low_in;
         key_high_ff    <= key_high_in;
         dev_addr_ff    <= dev_addr_in;
         block_index_ff <= block_index_in;
         valid0_ff      <= valid0_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv0) begin
         state0_ff <= ctr_block ^ key_full;
         key0_ff   <= key_full;
         side0_ff  <= side_req;
      end
   end

   for (genvar r = 0; r < ROUNDS; r++) begin : g_round
      if (r == 0) begin : g_first
         acpc_round u_round (
            .clock      (clock),
            .reset      (reset),
            .advance    (rnd_adv[r]),
            .valid_prev (valid0_ff),
            .state_prev (state0_ff),
            .key_prev   (key0_ff),
            .side_prev  (side0_ff),
            .rcon       (RCON_TABLE[r]),
            .last       (1'b0),
            .valid_ff   (rnd_valid[r]),
            .state_ff   (rnd_state[r]),
            .key_ff     (rnd_key[r]),
            .side_ff    (rnd_side[r])
         );
      end else begin : g_next
         acpc_round u_round (
            .clock      (clock),
            .reset      (reset),
            .advance    (rnd_adv[r]),
            .valid_prev (rnd_valid[r-1]),
            .state_prev (rnd_state[r-1]),
            .key_prev   (rnd_key[r-1]),
            .side_prev  (rnd_side[r-1]),
            .rcon       (RCON_TABLE[r]),
            .last       (r == ROUNDS - 1),
            .valid_ff   (rnd_valid[r]),
            .state_ff   (rnd_state[r]),
            .key_ff     (rnd_key[r]),
            .side_ff    (rnd_side[r])
         );
      end
   end

   // Merge: keystream XOR payload on the valid bytes, zero on the rest.
   for (genvar b = 0; b < BLOCK_BYTES; b++) begin : g_merge
      assign out_data_in[8*b +: 8] =
         (COUNT_W'(b) < rnd_side[ROUNDS-1].count) ?
         (rnd_state[ROUNDS-1][8*b +: 8] ^ rnd_side[ROUNDS-1].data[8*b +: 8]) : 8'h00;
   end

   assign out_valid_in = out_adv ? rnd_valid[ROUNDS-1] : out_valid_ff;

   always_ff @(posedge clock) begin
      if (out_adv) begin
         out_data_ff  <= out_data_in;
         out_count_ff <= rnd_side[ROUNDS-1].count;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_result_low   = out_data_ff[63:0];
   assign rsp_result_high  = out_data_ff[127:64];
   assign rsp_result_count = out_count_ff;

endmodule
